// ----- src/bcc_pkg.sv -----
// Shared constants and types for the button click classifier.
package bcc_pkg;

   // Widest button count the request and register fields can carry
   localparam int MAX_BUTTONS  = 4;
   localparam int TIMEOUT_W    = 16;
   localparam int EVENT_W      = 3;
   localparam int INDEX_W      = 3;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET = 16'd50;
   localparam logic [MAX_BUTTONS-1:0] LEVELS_RESET  = 4'hF;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_BTN0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVELS = 3'd4;

   // Request kinds carried in tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Event codes latched per button and returned on a read
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 3'd0,
      EV_SINGLE  = 3'd1,
      EV_DOUBLE  = 3'd2,
      EV_HOLD    = 3'd3,
      EV_RELEASE = 3'd4,
      EV_INVALID = 3'd5
   } event_type;

endpackage

// ----- src/button_click_classifier_top.sv -----
// Four-button single, double and hold click classifier with stream ports.
//
// Usage:
//   The req channel carries two kinds of transfer, chosen by req_tuser.
//   A tick (req_tuser = 0) samples the raw pin levels in req_tdata[3:0];
//   every button state machine advances one step and no result follows.
//   A read (req_tuser = 1) names a button in req_tdata[6:4]; exactly one
//   result follows on rsp with that button's latched event, which is then
//   cleared, or the invalid code for an index at or above NUM_BUTTONS.
//   A read's result is on rsp in the cycle after its transfer unless an
//   earlier result still waits there. The block takes one transfer per
//   cycle while req_tready is high; the per-button next-state logic is
//   combinational.
//   When rsp stalls, one more result is held in a skid register and
//   req_tready drops only while that register is full.
//   Reset (synchronous, active high) sets every timeout to 50, all active
//   levels high, every button idle with no latched event, and empties rsp.
//   The csr port writes timeouts (index 0..3) and active levels (index 4);
//   write it only while the block is idle.
module button_click_classifier_top
   import bcc_pkg::*;
#(
   parameter int NUM_BUTTONS = MAX_BUTTONS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [3:0] pin_levels, [6:4] button_index
   input  logic                   req_tuser,   // [0] req_type
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [2:0] event_code
   // Configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0]   csr_wdata
);

   localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [INDEX_W:0] NUM_BTN_L = (INDEX_W+1)'(NUM_BUTTONS);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FIRST  = 3'd1,
      PH_GAP    = 3'd2,
      PH_SECOND = 3'd3,
      PH_HOLD   = 3'd4
   } phase_type;

   // Configuration registers
   logic [TIMEOUT_W-1:0]   timeout_ff [NUM_BUTTONS];
   logic [MAX_BUTTONS-1:0] levels_ff;

   // Per-button state
   phase_type            phase_ff [NUM_BUTTONS];
   phase_type            phase_in [NUM_BUTTONS];
   logic [TIMEOUT_W-1:0] ticks_ff [NUM_BUTTONS];
   logic [TIMEOUT_W-1:0] ticks_in [NUM_BUTTONS];
   event_type            event_ff [NUM_BUTTONS];
   event_type            event_in [NUM_BUTTONS];

   // Result register and skid register
   logic             out_valid_ff;
   event_type        out_code_ff;
   logic             skid_valid_ff;
   event_type        skid_code_ff;

   logic                 req_xfer;
   logic                 tick_xfer;
   logic                 read_xfer;
   logic                 rsp_xfer;
   logic [MAX_BUTTONS-1:0] pins;
   logic [INDEX_W-1:0]   read_idx;
   logic                 idx_ok;
   logic [BTN_IDX_W-1:0] btn_sel;
   event_type            read_code;

   assign pins      = req_tdata[3:0];
   assign read_idx  = req_tdata[6:4];
   assign req_tready = !skid_valid_ff;
   assign req_xfer  = req_tvalid && req_tready;
   assign tick_xfer = req_xfer && (req_tuser == REQ_TICK);
   assign read_xfer = req_xfer && (req_tuser == REQ_READ);
   assign rsp_xfer  = out_valid_ff && rsp_tready;

   assign idx_ok  = {1'b0, read_idx} < NUM_BTN_L;
   assign btn_sel = read_idx[BTN_IDX_W-1:0];
   assign read_code = idx_ok ? event_ff[btn_sel] : EV_INVALID;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8-EVENT_W){1'b0}}, out_code_ff};

   // Advance every button on a tick; clear the selected event on a read
   always_comb begin
      logic                 pressed;
      logic [TIMEOUT_W-1:0] ticks_inc;
      logic                 hit;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         phase_in[b] = phase_ff[b];
         ticks_in[b] = ticks_ff[b];
         event_in[b] = event_ff[b];
         pressed   = !(pins[b] ^ levels_ff[b]);
         ticks_inc = ticks_ff[b] + 1'b1;
         hit       = (ticks_inc == timeout_ff[b]);
         if (tick_xfer) begin
            unique case (phase_ff[b])
               PH_IDLE: begin
                  if (pressed) begin
                     ticks_in[b] = '0;
                     phase_in[b] = PH_FIRST;
                  end
               end
               PH_FIRST: begin
                  ticks_in[b] = ticks_inc;
                  if (!pressed) begin
                     phase_in[b] = PH_GAP;
                  end else if (hit) begin
                     phase_in[b] = PH_HOLD;
                  end
               end
               PH_GAP: begin
                  ticks_in[b] = ticks_inc;
                  if (hit) begin
                     event_in[b] = EV_SINGLE;
                     phase_in[b] = PH_IDLE;
                  end
                  // A press in the same tick still starts the second press
                  if (pressed) begin
                     ticks_in[b] = '0;
                     phase_in[b] = PH_SECOND;
                  end
               end
               PH_SECOND: begin
                  ticks_in[b] = ticks_inc;
                  if (!pressed) begin
                     event_in[b] = EV_DOUBLE;
                     phase_in[b] = PH_IDLE;
                  end else if (hit) begin
                     phase_in[b] = PH_HOLD;
                  end
               end
               PH_HOLD: begin
                  if (!pressed) begin
                     event_in[b] = EV_RELEASE;
                     phase_in[b] = PH_IDLE;
                  end else begin
                     event_in[b] = EV_HOLD;
                  end
               end
               default: begin
                  phase_in[b] = phase_ff[b];
               end
            endcase
         end else if (read_xfer && idx_ok && (btn_sel == BTN_IDX_W'(b))) begin
            event_in[b] = EV_NONE;
         end
      end
   end

   // Hold configuration and button state
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            timeout_ff[b] <= TIMEOUT_RESET;
            phase_ff[b]   <= PH_IDLE;
            ticks_ff[b]   <= '0;
            event_ff[b]   <= EV_NONE;
         end
      end else begin
         if (csr_we && (csr_index == CSR_ACTIVE_LEVELS)) begin
            levels_ff <= csr_wdata[MAX_BUTTONS-1:0];
         end
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (csr_we && (csr_index == CSR_TIMEOUT_BTN0 + CSR_INDEX_W'(b))) begin
               timeout_ff[b] <= csr_wdata;
            end
            phase_ff[b] <= phase_in[b];
            ticks_ff[b] <= ticks_in[b];
            event_ff[b] <= event_in[b];
         end
      end
   end

   // Load the result register, spill into the skid register under stall
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_code_ff   <= skid_code_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (read_xfer) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_code_ff  <= read_code;
            out_valid_ff <= 1'b1;
         end else begin
            skid_code_ff  <= read_code;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTH
   // The skid register only ever holds a result behind a full result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   // Every accepted read shows a result on the next cycle
   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      read_xfer |=> rsp_tvalid)
      else $error("read transfer produced no result");

   // The skid register fills only when the result register was stalled
   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid register filled without a stall");

   // A held button 0 that stays pressed latches hold on every tick
   a_hold_latches: assert property (@(posedge clock) disable iff (reset)
      (tick_xfer && (phase_ff[0] == PH_HOLD) && !(pins[0] ^ levels_ff[0]))
         |=> (event_ff[0] == EV_HOLD))
      else $error("hold not latched for a held button");
`endif

endmodule

// ----- tb/button_click_classifier_top_tb.sv -----
// Self-checking testbench for the four-button click classifier.
module button_click_classifier_top_tb;
   import bcc_pkg::*;

   localparam int NUM_BTN = MAX_BUTTONS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   // Register index past the last one; writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [2:0] {
      BP_IDLE   = 3'd0,
      BP_FIRST  = 3'd1,
      BP_GAP    = 3'd2,
      BP_SECOND = 3'd3,
      BP_HOLD   = 3'd4
   } btn_phase_type;

   // Tracks every button state machine and the event codes that reads must return
   class click_scoreboard;
      logic [TIMEOUT_W-1:0] timeout_ticks[NUM_BTN];
      logic [NUM_BTN-1:0]   active_mask;
      btn_phase_type        btn_phase[NUM_BTN];
      logic [TIMEOUT_W-1:0] press_count[NUM_BTN];
      event_type            latched[NUM_BTN];
      event_type            pending_events[$];
      int                   errors;

      function new();
         for (int b = 0; b < NUM_BTN; b++) begin
            timeout_ticks[b] = TIMEOUT_RESET;
            btn_phase[b]     = BP_IDLE;
            press_count[b]   = '0;
            latched[b]       = EV_NONE;
         end
         active_mask = LEVELS_RESET;
         errors      = 0;
      endfunction

      function void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [TIMEOUT_W-1:0] value);
         if (idx < CSR_ACTIVE_LEVELS)
            timeout_ticks[idx - CSR_TIMEOUT_BTN0] = value;
         else if (idx == CSR_ACTIVE_LEVELS)
            active_mask = value[NUM_BTN-1:0];
      endfunction

      // Advance all buttons on a tick, or queue the event a read returns
      function void note_request(logic kind, logic [3:0] pins, logic [INDEX_W-1:0] idx);
         logic pressed;
         if (kind == REQ_TICK) begin
            for (int b = 0; b < NUM_BTN; b++) begin
               pressed = (pins[b] == active_mask[b]);
               case (btn_phase[b])
                  BP_IDLE: begin
                     if (pressed) begin
                        press_count[b] = '0;
                        btn_phase[b]   = BP_FIRST;
                     end
                  end
                  BP_FIRST: begin
                     press_count[b] = press_count[b] + 1'b1;
                     if (press_count[b] == timeout_ticks[b])
                        btn_phase[b] = BP_HOLD;
                     if (!pressed)
                        btn_phase[b] = BP_GAP;
                  end
                  BP_GAP: begin
                     press_count[b] = press_count[b] + 1'b1;
                     if (press_count[b] == timeout_ticks[b]) begin
                        latched[b]   = EV_SINGLE;
                        btn_phase[b] = BP_IDLE;
                     end
                     // a press on the deciding tick still starts a second press
                     if (pressed) begin
                        press_count[b] = '0;
                        btn_phase[b]   = BP_SECOND;
                     end
                  end
                  BP_SECOND: begin
                     press_count[b] = press_count[b] + 1'b1;
                     if (press_count[b] == timeout_ticks[b])
                        btn_phase[b] = BP_HOLD;
                     if (!pressed) begin
                        latched[b]   = EV_DOUBLE;
                        btn_phase[b] = BP_IDLE;
                     end
                  end
                  BP_HOLD: begin
                     latched[b] = EV_HOLD;
                     if (!pressed) begin
                        latched[b]   = EV_RELEASE;
                        btn_phase[b] = BP_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
         end else if (idx >= NUM_BTN) begin
            pending_events.push_back(EV_INVALID);
         end else begin
            pending_events.push_back(latched[idx]);
            latched[idx] = EV_NONE;
         end
      endfunction

      // Compare one returned event with the oldest pending one
      function void check_event(logic [7:0] data);
         event_type want;
         if (pending_events.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] unexpected event code %0d, none pending", $time,
                        data[EVENT_W-1:0]);
            return;
         end
         want = pending_events.pop_front();
         if (data[EVENT_W-1:0] !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] event code mismatch: expected %0d (%s), got %0d", $time,
                        want, want.name(), data[EVENT_W-1:0]);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [3:0] pin_levels, [6:4] button_index
   logic                   req_tuser;   // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [2:0] event_code
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [TIMEOUT_W-1:0]   csr_wdata;

   click_scoreboard        board;
   logic [NUM_BTN-1:0]     held_buttons;
   int                     rsp_stall_req;
   int                     rsp_stall_done;
   bit                     rsp_steady;
   int                     rsp_hold;
   int                     cycle_count;

   button_click_classifier_top #(
      .NUM_BUTTONS(NUM_BTN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Check each result transfer, then pick the next ready level
   initial begin
      rsp_hold       = 0;
      rsp_stall_done = 0;
      rsp_tready    <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_event(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (rsp_stall_done != rsp_stall_req) begin
            rsp_stall_done = rsp_stall_req;
            rsp_hold       = 59;
            rsp_tready    <= 1'b0;
         end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
                                                     : $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the transfer, then idle for gap cycles
   task automatic send_item(input logic kind, input logic [3:0] pins,
                            input logic [INDEX_W-1:0] idx, input int gap);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, idx, pins};
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      board.note_request(kind, pins, idx);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Tick with the given buttons pressed under the current active levels
   task automatic send_tick(input logic [NUM_BTN-1:0] press_mask, input int gap);
      logic [INDEX_W-1:0] noise;
      noise = INDEX_W'($urandom_range(0, 7));
      send_item(REQ_TICK, ~(press_mask ^ board.active_mask), noise, gap);
   endtask

   task automatic send_read(input logic [INDEX_W-1:0] idx, input int gap);
      logic [3:0] noise;
      noise = 4'($urandom_range(0, 15));
      send_item(REQ_READ, noise, idx, gap);
   endtask

   // Drop valid and wait until every result has come and the pipe is quiet
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending_events.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [TIMEOUT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.apply_csr(idx, value);
   endtask

   // Write all registers while the block is idle
   task automatic apply_settings(input logic [TIMEOUT_W-1:0] t0, t1, t2, t3,
                                 input logic [NUM_BTN-1:0] levels, input bit poke_unused);
      wait_drained();
      csr_write(CSR_TIMEOUT_BTN0,         t0);
      csr_write(CSR_TIMEOUT_BTN0 + 3'd1,  t1);
      csr_write(CSR_TIMEOUT_BTN0 + 3'd2,  t2);
      csr_write(CSR_TIMEOUT_BTN0 + 3'd3,  t3);
      csr_write(CSR_ACTIVE_LEVELS, {{(TIMEOUT_W-NUM_BTN){1'b0}}, levels});
      if (poke_unused)
         csr_write(CSR_UNUSED, TIMEOUT_W'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
   endtask

   // Random ticks and reads; button presses mostly persist across ticks
   task automatic run_traffic(input int count, input bit steady, input bit pressure);
      logic [3:0]         pins;
      logic [INDEX_W-1:0] idx;
      int                 gap;
      rsp_steady = steady;
      for (int n = 0; n < count; n++) begin
         if (pressure && n == count / 4)
            wait_drained();
         if (pressure && n == count / 2) begin
            // stall the receiver and keep reading so the block backs up
            rsp_stall_req++;
            repeat (30) send_read(INDEX_W'($urandom_range(0, NUM_BTN - 1)), 0);
         end
         gap = steady ? 0 : gap_len();
         if ($urandom_range(0, 9) < 3) begin
            idx = ($urandom_range(0, 6) == 0) ? INDEX_W'($urandom_range(NUM_BTN, 7))
                                              : INDEX_W'($urandom_range(0, NUM_BTN - 1));
            send_read(idx, gap);
         end else begin
            if ($urandom_range(0, 4) == 0) begin
               pins = 4'($urandom_range(0, 15));
            end else begin
               for (int b = 0; b < NUM_BTN; b++)
                  if ($urandom_range(0, 3) == 0)
                     held_buttons[b] = ~held_buttons[b];
               pins = ~(held_buttons ^ board.active_mask);
            end
            idx = INDEX_W'($urandom_range(0, 7));
            send_item(REQ_TICK, pins, idx, gap);
         end
      end
      rsp_steady = 1'b0;
   endtask

   initial begin
      board          = new();
      held_buttons   = '0;
      rsp_steady     = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= REQ_TICK;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: hold and release on button 0, single then press on the
      // deciding tick on button 1, double on button 2, a long gap on button 3
      apply_settings(16'd1, 16'd2, 16'd3, 16'hFFFF, 4'b1001, 1'b0);
      send_read(0, 0);
      send_read(4, 0);
      send_read(7, 0);
      send_tick(4'b1111, 0);
      send_tick(4'b0001, 0);
      send_tick(4'b0101, 0);
      send_read(0, 0);
      send_read(1, 0);
      send_tick(4'b0010, 0);
      send_read(0, 0);
      send_read(2, 0);
      send_read(0, 0);
      send_tick(4'b1000, 0);
      send_tick(4'b0010, 0);
      send_read(1, 0);
      send_read(3, 0);
      send_tick(4'b0000, 0);
      send_read(1, 0);
      send_read(1, 0);
      send_read(5, 0);
      send_read(6, 0);

      // Random phases across several register settings
      apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 4'b0000, 1'b0);
      run_traffic(105, 1'b0, 1'b0);
      apply_settings(TIMEOUT_W'($urandom_range(2, 6)), TIMEOUT_W'($urandom_range(2, 6)),
                     TIMEOUT_W'($urandom_range(2, 6)), TIMEOUT_W'($urandom_range(2, 6)),
                     4'b1111, 1'b0);
      run_traffic(75, 1'b0, 1'b1);
      apply_settings(16'hFFFF, 16'hFFFF, 16'd3, 16'd4, NUM_BTN'($urandom_range(0, 15)), 1'b0);
      run_traffic(105, 1'b0, 1'b0);
      apply_settings(TIMEOUT_W'($urandom_range(1, 10)), TIMEOUT_W'($urandom_range(1, 10)),
                     TIMEOUT_W'($urandom_range(1, 10)), TIMEOUT_W'($urandom_range(1, 10)),
                     NUM_BTN'($urandom_range(0, 15)), 1'b0);
      run_traffic(105, 1'b1, 1'b0);
      apply_settings(TIMEOUT_W'($urandom_range(1, 8)), TIMEOUT_W'($urandom_range(1, 8)),
                     TIMEOUT_W'($urandom_range(1, 8)), TIMEOUT_W'($urandom_range(1, 8)),
                     4'b0101, 1'b1);
      run_traffic(105, 1'b0, 1'b0);
      apply_settings(TIMEOUT_W'($urandom_range(1, 12)), TIMEOUT_W'($urandom_range(1, 40)),
                     TIMEOUT_W'($urandom_range(1, 5)), TIMEOUT_W'($urandom_range(200, 65535)),
                     NUM_BTN'($urandom_range(0, 15)), 1'b0);
      run_traffic(105, 1'b0, 1'b0);

      // Let the last results drain
      req_tvalid <= 1'b0;
      while (board.pending_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending_events.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/bcc_pkg.sv
src/button_click_classifier_top.sv
tb/button_click_classifier_top_tb.sv
